// ===== hw/rtl/pidtf_pkg.sv =====
package pidtf_pkg;

    localparam int DATA_WIDTH     = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_WIDTH     = 16;
    localparam int INTEG_WIDTH    = 32;
    localparam int PDATA_WIDTH    = 32;
    localparam int N_REGS         = 8;
    localparam int ADDR_WIDTH     = $clog2(N_REGS) + 2;
    localparam int PIPE_DEPTH     = 2;

    // error and its first and second differences
    localparam int ERR_WIDTH   = DATA_WIDTH + 1;
    localparam int DIFF1_WIDTH = DATA_WIDTH + 2;
    localparam int DIFF2_WIDTH = DATA_WIDTH + 3;
    localparam int OPB_WIDTH   = (INTEG_WIDTH > DIFF2_WIDTH) ? INTEG_WIDTH : DIFF2_WIDTH;

    localparam int PROD_P_WIDTH  = GAIN_WIDTH + DIFF1_WIDTH;
    localparam int PROD_I_WIDTH  = GAIN_WIDTH + OPB_WIDTH;
    localparam int PROD_D_WIDTH  = GAIN_WIDTH + DIFF2_WIDTH;
    localparam int SUM_WIDTH     = PROD_I_WIDTH + 2;
    localparam int SHIFT_WIDTH   = SUM_WIDTH - GAIN_FRAC_BITS;
    localparam int DRV_SUM_WIDTH = SHIFT_WIDTH + 1;

    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } t_mode;

    typedef enum logic {
        CMD_STEP  = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd;

    typedef enum logic [ADDR_WIDTH-3:0] {
        REG_MODE,
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_OUT_UPPER,
        REG_OUT_LOWER,
        REG_INTEG_UPPER,
        REG_INTEG_LOWER
    } t_reg_idx;

endpackage

// ===== hw/rtl/pid_controller_two_form_unit.sv =====
// PID controller with a positional and an incremental form, selected by the mode register.
// Each beat carries a setpoint and a measurement (or a clear command) and yields one
// clamped drive value. A beat lands in the input register, where its error is formed; the
// integral clamp, the three gain products, their sum and scaling and the output clamp all
// settle between the input register and the result register, which loads the result once
// the output is not stalled. The block takes one beat per clock while the output does not
// stall. An output stall holds the result register, and the input stalls only once the
// input register is full as well. Results come out in order. The user must write registers
// over the APB port only while no beat is in flight; the block itself does not enforce it.
module pid_controller_two_form_unit (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [pidtf_pkg::ADDR_WIDTH-1:0]            paddr,
    input  logic [pidtf_pkg::PDATA_WIDTH-1:0]           pwdata,
    output logic [pidtf_pkg::PDATA_WIDTH-1:0]           prdata,
    output logic                                        pready,
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  logic                                        i_command,
    input  logic signed [pidtf_pkg::DATA_WIDTH-1:0]     i_setpoint,
    input  logic signed [pidtf_pkg::DATA_WIDTH-1:0]     i_measured,
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output logic signed [pidtf_pkg::DATA_WIDTH-1:0]     o_drive
);

    localparam int DW   = pidtf_pkg::DATA_WIDTH;
    localparam int GW   = pidtf_pkg::GAIN_WIDTH;
    localparam int IW   = pidtf_pkg::INTEG_WIDTH;
    localparam int EW   = pidtf_pkg::ERR_WIDTH;
    localparam int D1W  = pidtf_pkg::DIFF1_WIDTH;
    localparam int D2W  = pidtf_pkg::DIFF2_WIDTH;
    localparam int OBW  = pidtf_pkg::OPB_WIDTH;
    localparam int PPW  = pidtf_pkg::PROD_P_WIDTH;
    localparam int PIW  = pidtf_pkg::PROD_I_WIDTH;
    localparam int PDW  = pidtf_pkg::PROD_D_WIDTH;
    localparam int SW   = pidtf_pkg::SUM_WIDTH;
    localparam int SHW  = pidtf_pkg::SHIFT_WIDTH;
    localparam int DSW  = pidtf_pkg::DRV_SUM_WIDTH;
    localparam int PW   = pidtf_pkg::PDATA_WIDTH;

    // configuration registers
    pidtf_pkg::t_mode        r_mode;
    logic signed [GW-1:0]    r_gain_p;
    logic signed [GW-1:0]    r_gain_i;
    logic signed [GW-1:0]    r_gain_d;
    logic signed [DW-1:0]    r_out_upper;
    logic signed [DW-1:0]    r_out_lower;
    logic signed [IW-1:0]    r_integ_upper;
    logic signed [IW-1:0]    r_integ_lower;

    // controller state
    logic signed [IW-1:0]    r_integ;
    logic signed [EW-1:0]    r_last_err;
    logic signed [EW-1:0]    r_older_err;
    logic signed [DW-1:0]    r_last_drive;

    // input and result registers
    logic                    r_in_valid;
    pidtf_pkg::t_cmd         r_in_cmd;
    logic signed [EW-1:0]    r_in_err;
    logic                    r_out_valid;
    logic signed [DW-1:0]    r_out_drive;

    logic                    rdy_in, rdy_out;
    logic                    mv_in, mv_out;
    logic                    cfg_we;
    pidtf_pkg::t_reg_idx     cfg_idx;

    logic signed [OBW:0]     integ_sum;
    logic signed [IW-1:0]    integ_new;
    logic signed [D1W-1:0]   diff1;
    logic signed [D2W-1:0]   diff2;
    logic signed [D1W-1:0]   op_a;
    logic signed [OBW-1:0]   op_b;
    logic signed [D2W-1:0]   op_c;
    logic signed [PPW-1:0]   prod_p;
    logic signed [PIW-1:0]   prod_i;
    logic signed [PDW-1:0]   prod_d;
    logic signed [SW-1:0]    sum_all;
    logic signed [SHW-1:0]   sum_shift;
    logic signed [DSW-1:0]   drv_sum;
    logic signed [DW-1:0]    n_drive;

    // ---------------------------------------------------------------- handshake
    assign rdy_out = !r_out_valid || !i_out_stall;
    assign rdy_in  = !r_in_valid || rdy_out;

    assign mv_in  = i_in_valid && rdy_in;
    assign mv_out = r_in_valid && rdy_out;

    assign o_in_stall  = !rdy_in;
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_out_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy_in) begin
                r_in_valid <= i_in_valid;
            end
            if (rdy_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // ---------------------------------------------------------------- config port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = pidtf_pkg::t_reg_idx'(paddr[pidtf_pkg::ADDR_WIDTH-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= pidtf_pkg::MODE_POSITIONAL;
            r_gain_p      <= '0;
            r_gain_i      <= '0;
            r_gain_d      <= '0;
            r_out_upper   <= {1'b0, {(DW-1){1'b1}}};
            r_out_lower   <= {1'b1, {(DW-1){1'b0}}};
            r_integ_upper <= {1'b0, {(IW-1){1'b1}}};
            r_integ_lower <= {1'b1, {(IW-1){1'b0}}};
        end else if (cfg_we) begin
            unique case (cfg_idx)
                pidtf_pkg::REG_MODE:        r_mode        <= pidtf_pkg::t_mode'(pwdata[0]);
                pidtf_pkg::REG_GAIN_P:      r_gain_p      <= pwdata[GW-1:0];
                pidtf_pkg::REG_GAIN_I:      r_gain_i      <= pwdata[GW-1:0];
                pidtf_pkg::REG_GAIN_D:      r_gain_d      <= pwdata[GW-1:0];
                pidtf_pkg::REG_OUT_UPPER:   r_out_upper   <= pwdata[DW-1:0];
                pidtf_pkg::REG_OUT_LOWER:   r_out_lower   <= pwdata[DW-1:0];
                pidtf_pkg::REG_INTEG_UPPER: r_integ_upper <= pwdata[IW-1:0];
                pidtf_pkg::REG_INTEG_LOWER: r_integ_lower <= pwdata[IW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            pidtf_pkg::REG_MODE:        prdata = PW'(r_mode);
            pidtf_pkg::REG_GAIN_P:      prdata = PW'(r_gain_p);
            pidtf_pkg::REG_GAIN_I:      prdata = PW'(r_gain_i);
            pidtf_pkg::REG_GAIN_D:      prdata = PW'(r_gain_d);
            pidtf_pkg::REG_OUT_UPPER:   prdata = PW'(r_out_upper);
            pidtf_pkg::REG_OUT_LOWER:   prdata = PW'(r_out_lower);
            pidtf_pkg::REG_INTEG_UPPER: prdata = PW'(r_integ_upper);
            pidtf_pkg::REG_INTEG_LOWER: prdata = PW'(r_integ_lower);
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input register
    always_ff @(posedge i_clk) begin
        if (mv_in) begin
            r_in_cmd <= pidtf_pkg::t_cmd'(i_command);
            r_in_err <= EW'(i_setpoint) - EW'(i_measured);
        end
    end

    // ---------------------------------------------------------------- integral, differences
    assign integ_sum = (OBW+1)'(r_integ) + (OBW+1)'(r_in_err);

    // when the limits cross, the upper limit applies to a sum above it and the lower to the rest
    always_comb begin
        if (integ_sum > (OBW+1)'(r_integ_upper)) begin
            integ_new = r_integ_upper;
        end else if (integ_sum < (OBW+1)'(r_integ_lower)) begin
            integ_new = r_integ_lower;
        end else begin
            integ_new = IW'(integ_sum);
        end
    end

    assign diff1 = D1W'(r_in_err) - D1W'(r_last_err);
    assign diff2 = D2W'(r_in_err) - (D2W'(r_last_err) <<< 1) + D2W'(r_older_err);

    always_comb begin
        if (r_mode == pidtf_pkg::MODE_POSITIONAL) begin
            op_a = D1W'(r_in_err);
            op_b = OBW'(integ_new);
            op_c = D2W'(diff1);
        end else begin
            op_a = diff1;
            op_b = OBW'(r_in_err);
            op_c = diff2;
        end
    end

    // ---------------------------------------------------------------- gains, sum, scale
    assign prod_p = PPW'(r_gain_p) * PPW'(op_a);
    assign prod_i = PIW'(r_gain_i) * PIW'(op_b);
    assign prod_d = PDW'(r_gain_d) * PDW'(op_c);

    assign sum_all   = SW'(prod_p) + SW'(prod_i) + SW'(prod_d);
    assign sum_shift = SHW'(sum_all >>> pidtf_pkg::GAIN_FRAC_BITS);

    // ---------------------------------------------------------------- drive
    assign drv_sum = (r_mode == pidtf_pkg::MODE_INCREMENTAL)
                   ? DSW'(sum_shift) + DSW'(r_last_drive)
                   : DSW'(sum_shift);

    always_comb begin
        if (r_in_cmd == pidtf_pkg::CMD_CLEAR) begin
            n_drive = '0;
        end else if (drv_sum > DSW'(r_out_upper)) begin
            n_drive = r_out_upper;
        end else if (drv_sum < DSW'(r_out_lower)) begin
            n_drive = r_out_lower;
        end else begin
            n_drive = DW'(drv_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ      <= '0;
            r_last_err   <= '0;
            r_older_err  <= '0;
            r_last_drive <= '0;
        end else if (mv_out) begin
            if (r_in_cmd == pidtf_pkg::CMD_CLEAR) begin
                r_integ     <= '0;
                r_last_err  <= '0;
                r_older_err <= '0;
            end else if (r_mode == pidtf_pkg::MODE_POSITIONAL) begin
                r_integ    <= integ_new;
                r_last_err <= r_in_err;
            end else begin
                r_older_err <= r_last_err;
                r_last_err  <= r_in_err;
            end
            // drive is zero on a clear
            r_last_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv_out) begin
            r_out_drive <= n_drive;
        end
    end

endmodule

// ===== hw/rtl/pidtf_checker.sv =====
module pidtf_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    o_in_stall,
    input  logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    input  logic signed [pidtf_pkg::DATA_WIDTH-1:0] o_drive,
    input  logic                                    pready
);

    localparam int CW = $clog2(pidtf_pkg::PIPE_DEPTH + 1);

    logic          acc_in;
    logic          acc_out;
    logic [CW-1:0] r_cnt;

    assign acc_in  = i_in_valid && !o_in_stall;
    assign acc_out = o_out_valid && !i_out_stall;

    // track beats in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CW'(acc_in) - CW'(acc_out);
        end
    end

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_cnt != '0))
        else $error("result shown with no beat in flight");

    a_empty_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !o_in_stall)
        else $error("empty pipeline stalls input");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_drive)))
        else $error("stalled result changed");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("config port not ready");

endmodule

bind pid_controller_two_form_unit pidtf_checker u_pidtf_checker (.*);
